### design/bsce_pkg.sv
// Shared types, constants and tables for the binary softmax cross-entropy core.
package bsce_pkg;

	localparam int MaxItems = 65536;
	localparam logic [14:0] Log10Of2 = 15'd19728;

	typedef struct packed {
		logic [15:0] prob_a;
		logic [15:0] prob_b;
		logic [15:0] item_loss;
		logic [15:0] grad_a;
		logic [15:0] grad_b;
		logic [15:0] mean_loss;
		logic        mean_valid;
		logic        saturated;
	} result_t;

	// e^-(2^(k-4)) in Q0.16 for exp argument bits 4..11
	function automatic logic [15:0] exp_const(input logic [2:0] k);
		logic [15:0] c;
		case (k)
			3'd0: c = 16'd61565;
			3'd1: c = 16'd57835;
			3'd2: c = 16'd51039;
			3'd3: c = 16'd39750;
			3'd4: c = 16'd24109;
			3'd5: c = 16'd8869;
			3'd6: c = 16'd1200;
			3'd7: c = 16'd22;
			default: c = 16'd0;
		endcase
		return c;
	endfunction

endpackage

### design/bsce_mul.sv
// Shared unsigned multiplier used by every product step of the sequencer.
module bsce_mul (
	input  logic [20:0] op_a,
	input  logic [16:0] op_b,
	output logic [37:0] prod
);

	assign prod = 38'(op_a) * 38'(op_b);

endmodule

### design/bsce_ctrl.sv
// Sequencer and datapath: exp, divide, normalize, log squarings, loss multiply, accumulate, mean.
module bsce_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        logit_a,
	input  logic [15:0]        logit_b,
	input  logic               true_class,
	input  logic               end_of_set,
	output logic               busy,
	output logic               done,
	input  logic               take,
	output bsce_pkg::result_t  result
);

	localparam logic [3:0] StIdle = 4'd0;
	localparam logic [3:0] StExp  = 4'd1;
	localparam logic [3:0] StDiv  = 4'd2;
	localparam logic [3:0] StNorm = 4'd3;
	localparam logic [3:0] StSqr  = 4'd4;
	localparam logic [3:0] StLoss = 4'd5;
	localparam logic [3:0] StAcc  = 4'd6;
	localparam logic [3:0] StDone = 4'd7;

	logic [3:0]  state_q;
	logic        neg_q, t_q, eos_q, sat_q, mdiv_q;
	logic [7:0]  xi_q;
	logic [2:0]  k_q;
	logic [16:0] v_q;
	logic [33:0] num_q;
	logic [17:0] den_q, rem_q;
	logic [5:0]  cnt_q;
	logic [16:0] pa_q, pb_q, f_q, y_q;
	logic [4:0]  sh_q;
	logic [3:0]  i_q;
	logic [15:0] frac_q, loss_q, mean_q;
	logic [31:0] sum_q;
	logic [16:0] count_q;

	logic [20:0] mul_a;
	logic [16:0] mul_b;
	logic [37:0] prod;

	logic [16:0] d, mag;
	logic [33:0] exp_rnd, sqr_rnd;
	logic [37:0] loss_rnd;
	logic [17:0] yn;
	logic [18:0] rem_sh;
	logic        ge;
	logic [16:0] s_val, pa_new, pb_new, ptrue;
	logic [20:0] l2;
	logic [32:0] sum_add;
	logic        cnt_ok, sum_ovf;
	logic [31:0] sum_new;
	logic [16:0] cnt_new;
	logic [17:0] gsum;
	logic [15:0] ga;

	bsce_mul u_mul (.op_a(mul_a), .op_b(mul_b), .prod(prod));

	always_comb begin
		case (state_q)
			StExp: begin
				mul_a = 21'(v_q);
				mul_b = 17'(bsce_pkg::exp_const(k_q));
			end
			StSqr: begin
				mul_a = 21'(y_q);
				mul_b = y_q;
			end
			StLoss: begin
				mul_a = l2;
				mul_b = 17'(bsce_pkg::Log10Of2);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign d = {logit_b[15], logit_b} - {logit_a[15], logit_a};
	assign mag = d[16] ? 17'd0 - d : d;

	assign exp_rnd = prod[33:0] + 34'd32768;
	assign rem_sh = {rem_q, num_q[33]};
	assign ge = rem_sh >= {1'b0, den_q};

	// quotient as it stands after the last divide step
	assign s_val = {num_q[15:0], ge};
	assign pa_new = neg_q ? 17'd65536 - s_val : s_val;
	assign pb_new = neg_q ? s_val : 17'd65536 - s_val;
	assign ptrue = t_q ? pa_new : pb_new;

	assign sqr_rnd = prod[33:0] + 34'd32768;
	assign yn = {prod[34] | sqr_rnd[33], sqr_rnd[32:16]};
	assign l2 = {sh_q, 16'd0} - 21'(frac_q);
	assign loss_rnd = prod + 38'd2097152;

	assign cnt_ok = count_q < 17'(bsce_pkg::MaxItems);
	assign sum_add = {1'b0, sum_q} + 33'(loss_q);
	assign sum_ovf = cnt_ok && sum_add[32];
	assign sum_new = !cnt_ok ? sum_q : (sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0]);
	assign cnt_new = cnt_ok ? count_q + 17'd1 : count_q;

	assign gsum = 18'(pa_q) + (t_q ? 18'd0 : 18'd65536) + 18'd128;
	assign ga = 16'(gsum[17:8]) - 16'd256;

	assign busy = state_q != StIdle;
	assign done = state_q == StDone;

	always_comb begin
		result.prob_a = pa_q[16] ? 16'hFFFF : pa_q[15:0];
		result.prob_b = pb_q[16] ? 16'hFFFF : pb_q[15:0];
		result.item_loss = loss_q;
		result.grad_a = ga;
		result.grad_b = 16'd0 - ga;
		result.mean_loss = eos_q ? mean_q : 16'd0;
		result.mean_valid = eos_q;
		result.saturated = sat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			sum_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				StIdle: begin
					if (start) begin
						neg_q <= d[16];
						xi_q <= (|mag[16:12]) ? 8'hFF : mag[11:4];
						t_q <= true_class;
						eos_q <= end_of_set;
						sat_q <= 1'b0;
						v_q <= 17'd65536;
						k_q <= '0;
						state_q <= StExp;
					end
				end
				StExp: begin
					if (xi_q[k_q]) begin
						v_q <= exp_rnd[32:16];
					end
					if (k_q == 3'd7) begin
						state_q <= StDiv;
					end
					k_q <= k_q + 3'd1;
				end
				StDiv: begin
					rem_q <= ge ? 18'(rem_sh - {1'b0, den_q}) : rem_sh[17:0];
					num_q <= {num_q[32:0], ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd33) begin
						state_q <= mdiv_q ? StDone : (ptrue == 17'd0 ? StAcc : StNorm);
					end
				end
				StNorm: begin
					if (f_q[16]) begin
						y_q <= {1'b1, f_q[15:8], 8'd0};
						frac_q <= '0;
						i_q <= '0;
						state_q <= StSqr;
					end else begin
						f_q <= {f_q[15:0], 1'b0};
						sh_q <= sh_q + 5'd1;
					end
				end
				StSqr: begin
					if (yn[17]) begin
						y_q <= yn[17:1];
						frac_q[4'd15 - i_q] <= 1'b1;
					end else begin
						y_q <= yn[16:0];
					end
					i_q <= i_q + 4'd1;
					if (i_q == 4'd15) begin
						state_q <= StLoss;
					end
				end
				StLoss: begin
					loss_q <= loss_rnd[37:22];
					state_q <= StAcc;
				end
				StAcc: begin
					if (sum_ovf) begin
						sat_q <= 1'b1;
					end
					if (eos_q) begin
						sum_q <= '0;
						count_q <= '0;
						num_q <= {2'b0, sum_new} + 34'(cnt_new >> 1);
						den_q <= 18'(cnt_new);
						rem_q <= '0;
						cnt_q <= '0;
						mdiv_q <= 1'b1;
						state_q <= StDiv;
					end else begin
						sum_q <= sum_new;
						count_q <= cnt_new;
						state_q <= StDone;
					end
				end
				StDone: begin
					if (take) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase

			if (state_q == StExp && k_q == 3'd7) begin
				num_q <= {1'b0, (xi_q[7] ? exp_rnd[32:16] : v_q), 16'd0}
					+ 34'((18'(xi_q[7] ? exp_rnd[32:16] : v_q) + 18'd65536) >> 1);
				den_q <= 18'(xi_q[7] ? exp_rnd[32:16] : v_q) + 18'd65536;
				rem_q <= '0;
				cnt_q <= '0;
				mdiv_q <= 1'b0;
			end
			if (state_q == StDiv && cnt_q == 6'd33) begin
				if (mdiv_q) begin
					mean_q <= (|num_q[32:15]) ? 16'hFFFF : {num_q[14:0], ge};
				end else begin
					pa_q <= pa_new;
					pb_q <= pb_new;
					f_q <= ptrue;
					sh_q <= '0;
					// zero probability: loss pinned at full scale
					if (ptrue == 17'd0) begin
						loss_q <= 16'hFFFF;
						sat_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

### design/binary_softmax_cross_entropy_core.sv
// Top level: stream handshakes around the iterative loss sequencer, with an output register.
//
// Input transactions on s_axis carry two Q8.8 logits in tdata (logit_a low,
// logit_b high), the true class bit in tuser and the end-of-set mark in tlast.
// Each input transaction yields one output transaction on m_axis: tdata holds
// prob_a, prob_b, item_loss, grad_a, grad_b, mean_loss from the lowest bit up,
// tuser holds the saturation flag and tlast marks the mean loss as valid.
// Each item passes through these steps from acceptance until ready rises again:
// 8 exp steps, a 34-step divide, a normalizing shift loop, 16 log squarings,
// a loss multiply, an accumulate, the final state and the idle cycle. An
// end-of-set item adds a second 34-step divide for the mean; a zero
// true-class probability skips the normalize, log squaring and loss multiply steps.
// All products go through one shared multiplier and both divides through one
// shift-subtract unit, which sets the rate.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register while the next item is computed; a stalled
// receiver holds the sequencer in its final state until the register frees.
// Reset clears the running loss sum and item count and empties the output.
module binary_softmax_cross_entropy_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // logit_a, logit_b
	input  logic        s_axis_tuser,  // true_class
	input  logic        s_axis_tlast,  // end_of_set
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // prob_a, prob_b, item_loss, grad_a, grad_b, mean_loss
	output logic        m_axis_tuser,  // saturated
	output logic        m_axis_tlast   // mean_valid
);

	logic              busy, done, take;
	bsce_pkg::result_t res;
	bsce_pkg::result_t out_q;
	logic              vld_q;

	assign s_axis_tready = !busy;
	assign take = done && (!vld_q || m_axis_tready);

	bsce_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (s_axis_tvalid && !busy),
		.logit_a    (s_axis_tdata[15:0]),
		.logit_b    (s_axis_tdata[31:16]),
		.true_class (s_axis_tuser),
		.end_of_set (s_axis_tlast),
		.busy       (busy),
		.done       (done),
		.take       (take),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take) begin
			vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {out_q.mean_loss, out_q.grad_b, out_q.grad_a,
		out_q.item_loss, out_q.prob_b, out_q.prob_a};
	assign m_axis_tuser = out_q.saturated;
	assign m_axis_tlast = out_q.mean_valid;

endmodule
